// ===== rtl/pmfa_pkg.sv =====
// pmfa_pkg: shared constants of the paged memory frame allocator
// request codes, status codes and parameter defaults; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package pmfa_pkg;

  localparam int MEM_BYTES_DEF        = 32768;
  localparam int ADDR_BYTES_DEF       = 3;
  localparam int TABLE_ENTRIES_DEF    = 64;
  localparam int FRAME_COUNT_DEF      = 64;
  localparam int PAGE_BYTES_DEF       = 256;
  localparam int FIRST_FRAME_ADDR_DEF = 256;

  localparam logic [2:0] FN_RD_WORD  = 3'd0;
  localparam logic [2:0] FN_RD_ENTRY = 3'd1;
  localparam logic [2:0] FN_WR_WORD  = 3'd2;
  localparam logic [2:0] FN_WR_ENTRY = 3'd3;
  localparam logic [2:0] FN_ALLOC    = 3'd4;
  localparam logic [2:0] FN_FREE     = 3'd5;
  localparam logic [2:0] FN_FIND     = 3'd6;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOROOM = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;

endpackage
`default_nettype wire

// ===== rtl/paged_memory_frame_allocator.sv =====
// paged_memory_frame_allocator: top level, request sequencer around a byte memory
// depends on pmfa_pkg and pmfa_ram
//
// usage:
//   request channel: func, addr, data, page_count; an item is taken at a clock
//   edge with start high and busy low. busy stays high until the item is served.
//   result channel: result_value and status, valid for one cycle while done is
//   high; the receiver cannot stall, the result is simply presented once.
//   one item at a time: busy drops in the cycle done is high, so the next item
//   can be taken at the edge that ends the result.
//   after rst the memory is cleared one byte per cycle, with busy high, before
//   the first item is taken.
//   all work goes through the byte memory, which has one write port and one
//   registered read port; words and entries move one byte at a time:
//     word or entry read, word or entry write: one byte after another
//     find free frame  reads every table entry, marks each frame that an
//                      entry points to, then picks the lowest free frame
//     allocate         as find, and also looks for a run of free entries;
//                      then writes one entry per page
//     free run         per page: read the entry, zero the page, clear the entry
//   out of range accesses answer without touching the memory.
`timescale 1ns / 1ps
`default_nettype none
module paged_memory_frame_allocator #(
  parameter int MEM_BYTES        = pmfa_pkg::MEM_BYTES_DEF,
  parameter int ADDR_BYTES       = pmfa_pkg::ADDR_BYTES_DEF,
  parameter int TABLE_ENTRIES    = pmfa_pkg::TABLE_ENTRIES_DEF,
  parameter int FRAME_COUNT      = pmfa_pkg::FRAME_COUNT_DEF,
  parameter int PAGE_BYTES       = pmfa_pkg::PAGE_BYTES_DEF,
  parameter int FIRST_FRAME_ADDR = pmfa_pkg::FIRST_FRAME_ADDR_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  func,
  input  wire logic [14:0] addr,
  input  wire logic [31:0] data,
  input  wire logic [6:0]  page_count,
  output logic             done,
  output logic      [31:0] result_value,
  output logic      [1:0]  status
);

  localparam int AW   = $clog2(MEM_BYTES);
  localparam int EW   = 8 * ADDR_BYTES;
  localparam int TW   = $clog2(TABLE_ENTRIES + 1);
  localparam int FW   = $clog2(FRAME_COUNT + 1);
  localparam int FIW  = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int PW   = $clog2(PAGE_BYTES + 1);
  localparam int SPAN = FRAME_COUNT * PAGE_BYTES;
  localparam int QW   = 22;

  localparam logic [31:0] MEM32   = 32'(MEM_BYTES);
  localparam logic [31:0] AB32    = 32'(ADDR_BYTES);
  localparam logic [31:0] FIRST32 = 32'(FIRST_FRAME_ADDR);
  localparam logic [QW-1:0] RECIP = QW'((2 ** QW + PAGE_BYTES - 1) / PAGE_BYTES);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_WR   = 4'd3;
  localparam logic [3:0] S_ZF   = 4'd4;
  localparam logic [3:0] S_RRES = 4'd5;
  localparam logic [3:0] S_SCAN = 4'd6;
  localparam logic [3:0] S_SCHK = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_PICK = 4'd9;
  localparam logic [3:0] S_FREE = 4'd10;
  localparam logic [3:0] S_FZ   = 4'd11;
  localparam logic [3:0] S_FE   = 4'd12;
  localparam logic [3:0] S_FIN  = 4'd13;
  localparam logic [3:0] S_MARK = 4'd14;

  logic [3:0]  state, ret;
  logic [2:0]  func_q;
  logic [14:0] addr_q;
  logic [6:0]  cnt_q;
  logic [31:0] rd_addr, acc, acc_next;
  logic [2:0]  rd_left;
  logic        rd_pend, rd_oob;
  logic [31:0] wr_addr, wr_val;
  logic [2:0]  wr_left;
  logic [32:0] z_addr;
  logic [PW-1:0] z_left;
  logic [AW:0] clr_addr;
  logic [TW-1:0] j, run, run_next, start_e;
  logic        found;
  logic [6:0]  idx;
  logic [FRAME_COUNT-1:0] used;
  logic [QW-1:0] dv_off;
  logic [2*QW-1:0] dv_prod;
  logic [FIW-1:0] dv_q;
  logic [FW-1:0] fp;
  logic        fp_ok;
  logic [31:0] fp_addr, ea;
  logic [7:0]  rdata;
  logic        ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]  ram_wdata;

  pmfa_ram #(.DEPTH(MEM_BYTES), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr[AW-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = 8'd0;
    case (state)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr[AW-1:0];
      end
      S_WR: begin
        ram_we    = (wr_addr < MEM32);
        ram_waddr = wr_addr[AW-1:0];
        ram_wdata = wr_val[31:24];
      end
      S_ZF: begin
        ram_we    = (z_left != '0) && !z_addr[32] && (z_addr < {1'b0, MEM32});
        ram_waddr = z_addr[AW-1:0];
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    acc_next = rd_pend ? {acc[23:0], (rd_oob ? 8'd0 : rdata)} : acc;
    run_next = (acc == 32'd0) ? run + TW'(1) : '0;
    dv_prod  = {{QW{1'b0}}, dv_off} * {{QW{1'b0}}, RECIP};
    fp_ok    = (fp < FW'(FRAME_COUNT));
    fp_addr  = fp_ok ? FIRST32 + 32'(fp) * 32'(PAGE_BYTES) : 32'd0;
    ea       = 32'(addr_q) + 32'(idx) * AB32;
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_addr <= '0;
      done     <= 1'b0;
      rd_pend  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + (AW+1)'(1);
          if (clr_addr == (AW+1)'(MEM_BYTES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            func_q       <= func;
            addr_q       <= addr;
            cnt_q        <= page_count;
            result_value <= 32'd0;
            status       <= pmfa_pkg::ST_OK;
            acc          <= 32'd0;
            rd_addr      <= 32'(addr);
            wr_addr      <= 32'(addr);
            case (func)
              pmfa_pkg::FN_RD_WORD, pmfa_pkg::FN_WR_WORD: begin
                if (32'(addr) + 32'd4 > MEM32) begin
                  status <= pmfa_pkg::ST_RANGE;
                  state  <= S_FIN;
                end else if (func == pmfa_pkg::FN_RD_WORD) begin
                  rd_left <= 3'd4;
                  ret     <= S_RRES;
                  state   <= S_RD;
                end else begin
                  wr_left <= 3'd4;
                  wr_val  <= data;
                  ret     <= S_FIN;
                  state   <= S_WR;
                end
              end
              pmfa_pkg::FN_RD_ENTRY, pmfa_pkg::FN_WR_ENTRY: begin
                if (32'(addr) + AB32 > MEM32) begin
                  status <= pmfa_pkg::ST_RANGE;
                  state  <= S_FIN;
                end else if (func == pmfa_pkg::FN_RD_ENTRY) begin
                  rd_left <= 3'(ADDR_BYTES);
                  ret     <= S_RRES;
                  state   <= S_RD;
                end else begin
                  wr_left <= 3'(ADDR_BYTES);
                  wr_val  <= data << (32 - EW);
                  ret     <= S_FIN;
                  state   <= S_WR;
                end
              end
              pmfa_pkg::FN_ALLOC, pmfa_pkg::FN_FIND: begin
                j     <= '0;
                run   <= '0;
                found <= 1'b0;
                used  <= '0;
                state <= S_SCAN;
              end
              pmfa_pkg::FN_FREE: begin
                idx   <= 7'd0;
                state <= S_FREE;
              end
              default: begin
                state <= S_FIN;
              end
            endcase
          end
        end
        S_RD: begin
          acc <= acc_next;
          if (rd_left != 3'd0) begin
            rd_oob  <= (rd_addr >= MEM32);
            rd_addr <= rd_addr + 32'd1;
            rd_left <= rd_left - 3'd1;
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
            state   <= ret;
          end
        end
        S_WR: begin
          wr_addr <= wr_addr + 32'd1;
          wr_val  <= {wr_val[23:0], 8'd0};
          wr_left <= wr_left - 3'd1;
          if (wr_left == 3'd1) begin
            state <= ret;
          end
        end
        S_ZF: begin
          if (z_left == '0 || z_addr[32]) begin
            state <= S_FE;
          end else begin
            z_addr <= z_addr + 33'd1;
            z_left <= z_left - PW'(1);
          end
        end
        S_RRES: begin
          result_value <= acc;
          state        <= S_FIN;
        end
        S_SCAN: begin
          if (j == TW'(TABLE_ENTRIES)) begin
            fp  <= '0;
            idx <= 7'd0;
            if (func_q == pmfa_pkg::FN_ALLOC && !found) begin
              status <= pmfa_pkg::ST_NOROOM;
              state  <= S_FIN;
            end else begin
              state <= S_PICK;
            end
          end else begin
            rd_addr <= 32'(j) * AB32;
            rd_left <= 3'(ADDR_BYTES);
            acc     <= 32'd0;
            ret     <= S_SCHK;
            state   <= S_RD;
          end
        end
        S_SCHK: begin
          run <= run_next;
          j   <= j + TW'(1);
          if (func_q == pmfa_pkg::FN_ALLOC && cnt_q != 7'd0 && !found &&
              32'(run_next) == 32'(cnt_q)) begin
            found   <= 1'b1;
            start_e <= TW'(32'(j) + 32'd1 - 32'(cnt_q));
          end
          if (acc >= FIRST32 && acc - FIRST32 < 32'(SPAN)) begin
            dv_off <= QW'(acc - FIRST32);
            state  <= S_DIV;
          end else begin
            state <= S_SCAN;
          end
        end
        S_DIV: begin
          dv_q  <= FIW'(dv_prod >> QW);
          state <= S_MARK;
        end
        S_MARK: begin
          if (32'(dv_q) * 32'(PAGE_BYTES) == 32'(dv_off)) begin
            used[dv_q] <= 1'b1;
          end
          state <= S_SCAN;
        end
        S_PICK: begin
          if (func_q == pmfa_pkg::FN_ALLOC && idx == cnt_q) begin
            result_value <= 32'(start_e) * AB32;
            state        <= S_FIN;
          end else if (fp_ok && used[fp[FIW-1:0]]) begin
            fp <= fp + FW'(1);
          end else if (func_q == pmfa_pkg::FN_FIND) begin
            result_value <= fp_addr;
            state        <= S_FIN;
          end else begin
            if (fp_ok) begin
              used[fp[FIW-1:0]] <= 1'b1;
            end
            wr_addr <= (32'(start_e) + 32'(idx)) * AB32;
            wr_val  <= fp_addr << (32 - EW);
            wr_left <= 3'(ADDR_BYTES);
            idx     <= idx + 7'd1;
            ret     <= S_PICK;
            state   <= S_WR;
          end
        end
        S_FREE: begin
          if (idx == cnt_q) begin
            state <= S_FIN;
          end else if (ea + AB32 > MEM32) begin
            status <= pmfa_pkg::ST_RANGE;
            idx    <= idx + 7'd1;
          end else begin
            rd_addr <= ea;
            wr_addr <= ea;
            rd_left <= 3'(ADDR_BYTES);
            acc     <= 32'd0;
            ret     <= S_FZ;
            state   <= S_RD;
          end
        end
        S_FZ: begin
          z_addr <= {1'b0, acc};
          z_left <= PW'(PAGE_BYTES);
          state  <= S_ZF;
        end
        S_FE: begin
          wr_val  <= 32'd0;
          wr_left <= 3'(ADDR_BYTES);
          idx     <= idx + 7'd1;
          ret     <= S_FREE;
          state   <= S_WR;
        end
        S_FIN: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pmfa_ram.sv =====
// pmfa_ram: byte-wide memory, one write port and one registered read port
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
module pmfa_ram #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/pmfa_checker.sv =====
// pmfa_checker: port-level assertions for the frame allocator
// depends on pmfa_pkg; bound to paged_memory_frame_allocator
`timescale 1ns / 1ps
`default_nettype none
module pmfa_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done,
  input wire logic [1:0] status
);

  // an accepted item keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted item did not raise busy");

  // result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held longer than one cycle");

  // a result only follows work
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("done without preceding busy");

  // status codes stay in range
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == pmfa_pkg::ST_OK || status == pmfa_pkg::ST_NOROOM ||
              status == pmfa_pkg::ST_RANGE)) else $error("bad status code");

  // memory clearing holds off items after reset
  a_reset_clear: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> busy) else $error("not busy after reset");

endmodule

bind paged_memory_frame_allocator pmfa_checker u_pmfa_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .status (status)
);
`default_nettype wire

// ===== tb/testbench.sv =====
// testbench: self-checking bench for paged_memory_frame_allocator
// drives request items, predicts each result from a byte-level memory image
// depends on pmfa_pkg and the rtl of the block
`timescale 1ns / 1ps
module testbench;

  localparam int MEMB = pmfa_pkg::MEM_BYTES_DEF;
  localparam int AB = pmfa_pkg::ADDR_BYTES_DEF;
  localparam int TE = pmfa_pkg::TABLE_ENTRIES_DEF;
  localparam int FC = pmfa_pkg::FRAME_COUNT_DEF;
  localparam int PB = pmfa_pkg::PAGE_BYTES_DEF;
  localparam int FFA = pmfa_pkg::FIRST_FRAME_ADDR_DEF;
  localparam int CYCLE_LIMIT = 6000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [2:0] func = '0;
  logic [14:0] addr = '0;
  logic [31:0] data = '0;
  logic [6:0] page_count = '0;
  logic done;
  logic [31:0] result_value;
  logic [1:0] status;

  paged_memory_frame_allocator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func), .addr(addr),
    .data(data), .page_count(page_count), .done(done),
    .result_value(result_value), .status(status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct packed {
    logic [31:0] value;
    logic [1:0] st;
  } answer_t;

  typedef struct {
    logic [2:0] f;
    logic [14:0] a;
    logic [31:0] d;
    logic [6:0] n;
    bit typed;
    answer_t ans;
  } row_t;

  logic [7:0] image [MEMB];
  bit frame_taken [FC];
  answer_t pending_answers [$];
  int errors = 0;
  int cycles = 0;
  int results_seen = 0;
  int sender_idle = 32;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  function automatic logic [31:0] rd_byte(input int unsigned a);
    return (a < MEMB) ? {24'd0, image[a]} : 32'd0;
  endfunction

  function automatic void wr_byte(input int unsigned a, input logic [31:0] v);
    if (a < MEMB) image[a] = v[7:0];
  endfunction

  function automatic bit fits(input int unsigned a, input int unsigned len);
    return a <= MEMB && len <= MEMB - a;
  endfunction

  function automatic logic [31:0] rd_entry(input int unsigned a);
    logic [31:0] v = 0;
    for (int i = 0; i < AB; i++) v = (v << 8) | rd_byte(a + i);
    return v;
  endfunction

  function automatic void wr_entry(input int unsigned a, input logic [31:0] v);
    for (int i = 0; i < AB; i++) wr_byte(a + i, v >> (8 * (AB - 1 - i)));
  endfunction

  function automatic void claim_frame(input logic [31:0] v);
    int unsigned off;
    if (v < FFA) return;
    off = v - FFA;
    if (off % PB != 0) return;
    if (off / PB < FC) frame_taken[off / PB] = 1'b1;
  endfunction

  function automatic void rescan_table();
    for (int k = 0; k < FC; k++) frame_taken[k] = 1'b0;
    for (int j = 0; j < TE; j++) claim_frame(rd_entry(j * AB));
  endfunction

  function automatic logic [31:0] lowest_free_frame();
    for (int k = 0; k < FC; k++) if (!frame_taken[k]) return FFA + k * PB;
    return 0;
  endfunction

  function automatic answer_t serve_request(input logic [2:0] f, input logic [14:0] a,
                                            input logic [31:0] d, input logic [6:0] n);
    answer_t r;
    bit found;
    bit clear;
    int unsigned first;
    int unsigned ea;
    logic [31:0] fa;
    logic [31:0] fr;
    r = '0;
    found = 0;
    first = 0;
    case (f)
      pmfa_pkg::FN_RD_WORD, pmfa_pkg::FN_WR_WORD: begin
        if (!fits(a, 4)) r.st = pmfa_pkg::ST_RANGE;
        else if (f == pmfa_pkg::FN_RD_WORD) begin
          for (int i = 0; i < 4; i++) r.value = (r.value << 8) | rd_byte(a + i);
        end else begin
          for (int i = 0; i < 4; i++) wr_byte(a + i, d >> (8 * (3 - i)));
        end
      end
      pmfa_pkg::FN_RD_ENTRY, pmfa_pkg::FN_WR_ENTRY: begin
        if (!fits(a, AB)) r.st = pmfa_pkg::ST_RANGE;
        else if (f == pmfa_pkg::FN_RD_ENTRY) r.value = rd_entry(a);
        else wr_entry(a, d);
      end
      pmfa_pkg::FN_ALLOC: begin
        if (n != 0) begin
          for (int i = 0; i < TE && !found; i++) begin
            if (i + n > TE) break;
            clear = 1;
            for (int j = 0; j < n && clear; j++) if (rd_entry((i + j) * AB) != 0) clear = 0;
            if (clear) begin
              found = 1;
              first = i;
            end
          end
        end
        if (!found) r.st = pmfa_pkg::ST_NOROOM;
        else begin
          rescan_table();
          for (int j = 0; j < n; j++) begin
            fr = lowest_free_frame();
            wr_entry((first + j) * AB, fr);
            claim_frame(fr);
          end
          r.value = first * AB;
        end
      end
      pmfa_pkg::FN_FREE: begin
        for (int i = 0; i < n; i++) begin
          ea = a + i * AB;
          if (!fits(ea, AB)) begin
            r.st = pmfa_pkg::ST_RANGE;
            continue;
          end
          fa = rd_entry(ea);
          for (int unsigned k = 0; k < PB; k++) wr_byte(fa + k, 0);
          wr_entry(ea, 0);
        end
      end
      pmfa_pkg::FN_FIND: begin
        rescan_table();
        r.value = lowest_free_frame();
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout");
      $display("Some tests failed");
      $finish;
    end
    if (!rst && done) begin
      results_seen <= results_seen + 1;
      if (pending_answers.size() == 0) begin
        report("unexpected result", result_value, 32'd0);
      end else begin
        answer_t w;
        w = pending_answers.pop_front();
        if (result_value !== w.value) report("result_value", result_value, w.value);
        if (status !== {1'b0, 1'b0} + w.st) report("status", {30'd0, status}, {30'd0, w.st});
      end
    end
  end

  task automatic issue(input row_t r);
    answer_t p;
    while ($urandom_range(99) < sender_idle) @(posedge clk);
    start <= 1'b1;
    func <= r.f;
    addr <= r.a;
    data <= r.d;
    page_count <= r.n;
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
    p = serve_request(r.f, r.a, r.d, r.n);
    if (r.typed && p !== r.ans) begin
      report("directed row", p.value, r.ans.value);
    end
    pending_answers.push_back(r.typed ? r.ans : p);
    @(posedge clk);
  endtask

  function automatic row_t mk(input logic [2:0] f, input logic [14:0] a, input logic [31:0] d,
                              input logic [6:0] n, input bit t, input logic [31:0] v,
                              input logic [1:0] s);
    row_t r;
    r.f = f; r.a = a; r.d = d; r.n = n; r.typed = t; r.ans.value = v; r.ans.st = s;
    return r;
  endfunction

  function automatic row_t random_row();
    row_t r;
    int pick;
    pick = $urandom_range(99);
    r.typed = 0;
    r.d = $urandom();
    r.n = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(1, 4));
    if ($urandom_range(3) == 0) r.a = 15'($urandom());
    else if ($urandom_range(1) == 0) r.a = 15'(AB * $urandom_range(TE - 1));
    else r.a = 15'($urandom_range(FFA, FFA + FC * PB + 8));
    if ($urandom_range(19) == 0) r.a = 15'(MEMB - $urandom_range(1, 5));
    if (pick < 20) r.f = pmfa_pkg::FN_ALLOC;
    else if (pick < 32) begin
      r.f = pmfa_pkg::FN_FREE;
      r.a = 15'(AB * $urandom_range(TE - 1));
      if ($urandom_range(9) == 0) r.a = 15'($urandom());
    end else if (pick < 42) r.f = pmfa_pkg::FN_FIND;
    else if (pick < 52) begin
      r.f = pmfa_pkg::FN_WR_ENTRY;
      if ($urandom_range(1) == 0) begin
        r.a = 15'(AB * $urandom_range(TE - 1));
        r.d = 32'((FFA + PB * $urandom_range(FC + 1)) + (($urandom_range(7) == 0) ? 1 : 0));
        if ($urandom_range(7) == 0) r.d = $urandom();
      end
    end else if (pick < 98) r.f = 3'($urandom_range(3));
    else r.f = 3'd7;
    return r;
  endfunction

  row_t directed [$];

  initial begin
    foreach (image[k]) image[k] = 8'd0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed.push_back(mk(pmfa_pkg::FN_RD_WORD, 15'd0, 0, 0, 1, 0, pmfa_pkg::ST_OK));
    directed.push_back(mk(pmfa_pkg::FN_FIND, 0, 0, 0, 1, FFA, pmfa_pkg::ST_OK));
    directed.push_back(mk(pmfa_pkg::FN_ALLOC, 0, 0, 0, 1, 0, pmfa_pkg::ST_NOROOM));
    directed.push_back(mk(pmfa_pkg::FN_ALLOC, 0, 0, 7'd65, 1, 0, pmfa_pkg::ST_NOROOM));
    directed.push_back(mk(pmfa_pkg::FN_ALLOC, 0, 0, 7'd127, 1, 0, pmfa_pkg::ST_NOROOM));
    directed.push_back(mk(pmfa_pkg::FN_RD_WORD, 15'h7ffd, 0, 0, 1, 0, pmfa_pkg::ST_RANGE));
    directed.push_back(mk(pmfa_pkg::FN_WR_WORD, 15'h7fff, 32'hffffffff, 0, 1, 0,
                          pmfa_pkg::ST_RANGE));
    directed.push_back(mk(pmfa_pkg::FN_RD_ENTRY, 15'h7ffe, 0, 0, 1, 0, pmfa_pkg::ST_RANGE));
    directed.push_back(mk(pmfa_pkg::FN_WR_ENTRY, 15'h7ffe, 32'hffffffff, 0, 1, 0,
                          pmfa_pkg::ST_RANGE));
    directed.push_back(mk(pmfa_pkg::FN_WR_WORD, 15'h7ffc, 32'hffffffff, 0, 1, 0,
                          pmfa_pkg::ST_OK));
    directed.push_back(mk(pmfa_pkg::FN_RD_WORD, 15'h7ffc, 0, 0, 1, 32'hffffffff,
                          pmfa_pkg::ST_OK));
    directed.push_back(mk(pmfa_pkg::FN_WR_ENTRY, 15'h7ffd, 32'hffffffff, 0, 1, 0,
                          pmfa_pkg::ST_OK));
    directed.push_back(mk(pmfa_pkg::FN_RD_ENTRY, 15'h7ffd, 0, 0, 1, 32'h00ffffff,
                          pmfa_pkg::ST_OK));
    directed.push_back(mk(pmfa_pkg::FN_ALLOC, 0, 0, 7'd64, 1, 0, pmfa_pkg::ST_OK));
    directed.push_back(mk(pmfa_pkg::FN_FIND, 0, 0, 0, 1, 0, pmfa_pkg::ST_OK));
    directed.push_back(mk(pmfa_pkg::FN_ALLOC, 0, 0, 7'd1, 1, 0, pmfa_pkg::ST_NOROOM));
    directed.push_back(mk(pmfa_pkg::FN_FREE, 15'd0, 0, 7'd64, 1, 0, pmfa_pkg::ST_OK));
    directed.push_back(mk(pmfa_pkg::FN_ALLOC, 0, 0, 7'd2, 0, 0, pmfa_pkg::ST_OK));
    directed.push_back(mk(pmfa_pkg::FN_WR_ENTRY, 15'd189, 32'h12345678, 0, 0, 0,
                          pmfa_pkg::ST_OK));
    directed.push_back(mk(pmfa_pkg::FN_FIND, 0, 0, 0, 0, 0, pmfa_pkg::ST_OK));
    directed.push_back(mk(pmfa_pkg::FN_FREE, 15'h7ffc, 0, 7'd3, 1, 0, pmfa_pkg::ST_RANGE));
    directed.push_back(mk(pmfa_pkg::FN_FREE, 15'd0, 0, 7'd127, 0, 0, pmfa_pkg::ST_OK));
    directed.push_back(mk(3'd7, 15'h7fff, 32'hffffffff, 7'd127, 1, 0, pmfa_pkg::ST_OK));
    directed.push_back(mk(pmfa_pkg::FN_RD_WORD, 15'd0, 0, 0, 0, 0, pmfa_pkg::ST_OK));
    foreach (directed[i]) issue(directed[i]);
    for (int i = 0; i < 850; i++) begin
      if (i == 283) sender_idle = 85;
      if (i == 566) sender_idle = 0;
      if (i == 400) begin
        while (pending_answers.size() != 0) @(posedge clk);
      end
      issue(random_row());
    end
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("covered word and entry access, allocate, free and frame search, %0d results",
             results_seen);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/pmfa_pkg.sv
rtl/pmfa_ram.sv
rtl/paged_memory_frame_allocator.sv
rtl/pmfa_checker.sv
tb/testbench.sv
